[rtl/stuffed_frame_receiver_top_macros.svh]
// assertion macros shared by the stuffed frame receiver modules
`ifndef STUFFED_FRAME_RECEIVER_TOP_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfr_pkg.sv]
// types, codes and constants of the stuffed frame receiver
package sfr_pkg;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;
  localparam int KIND_W = 3;
  localparam int RPK_W  = 2;
  localparam int IDX_W  = 2;

  // longest payload accepted in one frame
  localparam logic [CNT_W-1:0] MAX_PAYLOAD = 13'd4096;

  // line bytes
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7e;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7d;
  localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5e;
  localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h5d;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_STATION_ADDRESS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_INFO_ZERO_CODE  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INFO_ONE_CODE   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SET_CODE        = 2'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_STATION_ADDRESS = 8'd3;
  localparam logic [BYTE_W-1:0] RST_INFO_ZERO_CODE  = 8'd0;
  localparam logic [BYTE_W-1:0] RST_INFO_ONE_CODE   = 8'd64;
  localparam logic [BYTE_W-1:0] RST_SET_CODE        = 8'd3;

  // event codes
  localparam logic [KIND_W-1:0] EV_PAYLOAD = 3'd0;
  localparam logic [KIND_W-1:0] EV_ACCEPT  = 3'd1;
  localparam logic [KIND_W-1:0] EV_REJECT  = 3'd2;
  localparam logic [KIND_W-1:0] EV_DUP     = 3'd3;
  localparam logic [KIND_W-1:0] EV_HDR     = 3'd4;
  localparam logic [KIND_W-1:0] EV_SET     = 3'd5;

  // reply codes
  localparam logic [RPK_W-1:0] RP_RR  = 2'd0;
  localparam logic [RPK_W-1:0] RP_REJ = 2'd1;
  localparam logic [RPK_W-1:0] RP_UA  = 2'd2;

  // parser states
  typedef enum logic [3:0] {
    ST_HUNT   = 4'd0,
    ST_FLAG   = 4'd1,
    ST_ADDR   = 4'd2,
    ST_INFO_C = 4'd3,
    ST_SET_C  = 4'd4,
    ST_DATA   = 4'd5,
    ST_ESC    = 4'd6
  } state_t;

  // configuration registers
  typedef struct packed {
    logic [BYTE_W-1:0] station_address;
    logic [BYTE_W-1:0] info_zero_code;
    logic [BYTE_W-1:0] info_one_code;
    logic [BYTE_W-1:0] set_code;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              reply_valid;
    logic [RPK_W-1:0]  reply_kind;
    logic              reply_number;
    logic [CNT_W-1:0]  payload_length;
    logic              expected_number;
  } result_t;

endpackage

[rtl/sfr_if.sv]
// valid/ready channel interfaces for line bytes and result items

interface sfr_in_if;
  logic                     valid;
  logic                     ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::KIND_W-1:0] event_kind;
  logic [sfr_pkg::BYTE_W-1:0] payload_byte;
  logic                       reply_valid;
  logic [sfr_pkg::RPK_W-1:0]  reply_kind;
  logic                       reply_number;
  logic [sfr_pkg::CNT_W-1:0]  payload_length;
  logic                       expected_number;

  modport source (output valid, output event_kind, output payload_byte,
                  output reply_valid, output reply_kind, output reply_number,
                  output payload_length, output expected_number, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input reply_valid, input reply_kind, input reply_number,
                  input payload_length, input expected_number, output ready);
endinterface

[rtl/sfr_parser.sv]
// frame parser: header hunt, destuffing, bcc checks and sequence tracking
`include "stuffed_frame_receiver_top_macros.svh"

module sfr_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  input  sfr_pkg::cfg_t              cfg,
  output logic                       res_vld,
  output sfr_pkg::result_t           res
);

  sfr_pkg::state_t             state_r, state_nxt;
  logic                        exp_r, exp_nxt;
  logic                        frame_r, frame_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  held_r, held_nxt;
  logic                        held_vld_r, held_vld_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  xor_r, xor_nxt;
  logic [sfr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                        take;
  logic [sfr_pkg::BYTE_W-1:0]  take_byte;
  logic                        rej;
  logic                        dup;
  logic [sfr_pkg::BYTE_W-1:0]  ctrl;

  // next state and result for the current byte
  always_comb begin
    state_nxt    = state_r;
    exp_nxt      = exp_r;
    frame_nxt    = frame_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    xor_nxt      = xor_r;
    cnt_nxt      = cnt_r;
    res_vld      = 1'b0;
    res          = '0;
    take         = 1'b0;
    take_byte    = sfr_pkg::ZERO_BYTE;
    rej          = 1'b0;
    dup          = ((rx_byte == cfg.info_zero_code) && exp_r) ||
                   ((rx_byte == cfg.info_one_code) && !exp_r);
    ctrl         = frame_r ? cfg.info_one_code : cfg.info_zero_code;

    unique case (state_r)
      sfr_pkg::ST_FLAG: begin
        if (rx_byte == cfg.station_address) begin
          state_nxt = sfr_pkg::ST_ADDR;
        end else if (rx_byte != sfr_pkg::FLAG_BYTE) begin
          state_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_ADDR: begin
        if (dup) begin
          state_nxt        = sfr_pkg::ST_HUNT;
          res_vld          = 1'b1;
          res.event_kind   = sfr_pkg::EV_DUP;
          res.reply_valid  = 1'b1;
          res.reply_kind   = sfr_pkg::RP_RR;
          res.reply_number = exp_r;
        end else if (rx_byte == cfg.info_zero_code) begin
          frame_nxt = 1'b0;
          state_nxt = sfr_pkg::ST_INFO_C;
        end else if (rx_byte == cfg.info_one_code) begin
          frame_nxt = 1'b1;
          state_nxt = sfr_pkg::ST_INFO_C;
        end else if (rx_byte == cfg.set_code) begin
          state_nxt = sfr_pkg::ST_SET_C;
        end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
          state_nxt = sfr_pkg::ST_FLAG;
        end else begin
          state_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_INFO_C: begin
        if (rx_byte == (cfg.station_address ^ ctrl)) begin
          state_nxt    = sfr_pkg::ST_DATA;
          held_nxt     = sfr_pkg::ZERO_BYTE;
          held_vld_nxt = 1'b0;
          xor_nxt      = sfr_pkg::ZERO_BYTE;
          cnt_nxt      = '0;
        end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
          state_nxt = sfr_pkg::ST_FLAG;
        end else begin
          state_nxt        = sfr_pkg::ST_HUNT;
          res_vld          = 1'b1;
          res.event_kind   = sfr_pkg::EV_HDR;
          res.reply_valid  = 1'b1;
          res.reply_kind   = sfr_pkg::RP_RR;
          res.reply_number = exp_r;
        end
      end
      sfr_pkg::ST_SET_C: begin
        if (rx_byte == (cfg.station_address ^ cfg.set_code)) begin
          state_nxt       = sfr_pkg::ST_HUNT;
          res_vld         = 1'b1;
          res.event_kind  = sfr_pkg::EV_SET;
          res.reply_valid = 1'b1;
          res.reply_kind  = sfr_pkg::RP_UA;
        end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
          state_nxt = sfr_pkg::ST_FLAG;
        end else begin
          state_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_DATA: begin
        if (rx_byte == sfr_pkg::ESC_BYTE) begin
          state_nxt = sfr_pkg::ST_ESC;
        end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
          if (held_vld_r && (cnt_r != '0) && (xor_r == sfr_pkg::ZERO_BYTE)) begin
            state_nxt          = sfr_pkg::ST_HUNT;
            exp_nxt            = ~frame_r;
            res_vld            = 1'b1;
            res.event_kind     = sfr_pkg::EV_ACCEPT;
            res.reply_valid    = 1'b1;
            res.reply_kind     = sfr_pkg::RP_RR;
            res.reply_number   = ~frame_r;
            res.payload_length = cnt_r;
          end else begin
            rej = 1'b1;
          end
        end else begin
          take      = 1'b1;
          take_byte = rx_byte;
        end
      end
      sfr_pkg::ST_ESC: begin
        if (rx_byte == sfr_pkg::ESC_FLAG) begin
          take      = 1'b1;
          take_byte = sfr_pkg::FLAG_BYTE;
        end else if (rx_byte == sfr_pkg::ESC_ESC) begin
          take      = 1'b1;
          take_byte = sfr_pkg::ESC_BYTE;
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        state_nxt = (rx_byte == sfr_pkg::FLAG_BYTE) ? sfr_pkg::ST_FLAG : sfr_pkg::ST_HUNT;
      end
    endcase

    // destuffed data byte: release the held byte, hold the new one
    if (take) begin
      if (held_vld_r && (cnt_r >= sfr_pkg::MAX_PAYLOAD)) begin
        rej = 1'b1;
      end else begin
        if (held_vld_r) begin
          cnt_nxt          = cnt_r + 1'b1;
          res_vld          = 1'b1;
          res.event_kind   = sfr_pkg::EV_PAYLOAD;
          res.payload_byte = held_r;
        end
        held_nxt     = take_byte;
        held_vld_nxt = 1'b1;
        xor_nxt      = xor_r ^ take_byte;
        state_nxt    = sfr_pkg::ST_DATA;
      end
    end

    // frame rejected: reply with the number of the frame in progress
    if (rej) begin
      state_nxt        = sfr_pkg::ST_HUNT;
      res_vld          = 1'b1;
      res              = '0;
      res.event_kind   = sfr_pkg::EV_REJECT;
      res.reply_valid  = 1'b1;
      res.reply_kind   = sfr_pkg::RP_REJ;
      res.reply_number = frame_r;
    end

    res.expected_number = exp_nxt;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sfr_pkg::ST_HUNT;
      exp_r      <= 1'b0;
      frame_r    <= 1'b0;
      held_r     <= sfr_pkg::ZERO_BYTE;
      held_vld_r <= 1'b0;
      xor_r      <= sfr_pkg::ZERO_BYTE;
      cnt_r      <= '0;
    end else if (fire) begin
      state_r    <= state_nxt;
      exp_r      <= exp_nxt;
      frame_r    <= frame_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      xor_r      <= xor_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // an accepted frame flips the expected sequence bit
  `SFR_ASSERT_NEXT(a_accept_toggles, fire && res_vld && (res.event_kind == sfr_pkg::EV_ACCEPT), exp_r != $past(exp_r), "accept did not flip expected sequence")
  // payload count never passes the maximum
  `SFR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= sfr_pkg::MAX_PAYLOAD, "payload count beyond maximum")
  // the sequence bit only moves on an accepted frame
  `SFR_ASSERT_NEXT(a_exp_moves_on_accept, !(fire && res_vld && (res.event_kind == sfr_pkg::EV_ACCEPT)), $stable(exp_r), "expected sequence changed without accept")

endmodule

[rtl/sfr_result_reg.sv]
// result register between the parser and the output channel
`include "stuffed_frame_receiver_top_macros.svh"

module sfr_result_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfr_pkg::result_t res,
  output logic             out_free,
  sfr_out_if.source        out_ch
);

  logic             vld_r, vld_nxt;
  sfr_pkg::result_t res_r;

  assign out_free = !vld_r || out_ch.ready;

  // valid flag: set on load, cleared once the result is transferred
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = vld_r;
  assign out_ch.event_kind      = res_r.event_kind;
  assign out_ch.payload_byte    = res_r.payload_byte;
  assign out_ch.reply_valid     = res_r.reply_valid;
  assign out_ch.reply_kind      = res_r.reply_kind;
  assign out_ch.reply_number    = res_r.reply_number;
  assign out_ch.payload_length  = res_r.payload_length;
  assign out_ch.expected_number = res_r.expected_number;

  // a stalled result is never overwritten
  `SFR_ASSERT_NOW(a_no_overwrite, load, out_free, "result loaded over a stalled one")

endmodule

[rtl/stuffed_frame_receiver_top.sv]
// stuffed frame receiver top level: input register, config registers, parser, result register
// a line byte is held in the input register until the result register can take its result;
// it is then parsed, and any result it yields is loaded into the result register
// throughput: one line byte per cycle while the output side is ready
// reset (rst_n low, synchronous): parser hunts for a flag, sequence bits, counters and
// held byte cleared, config registers return to their defaults, both registers empty
`include "stuffed_frame_receiver_top_macros.svh"

module stuffed_frame_receiver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  sfr_in_if.sink                      in_ch,
  sfr_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [sfr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]  cfg_data
);

  logic                        in_vld_r, in_vld_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  in_byte_r;
  sfr_pkg::cfg_t               cfg_r;
  logic                        out_free;
  logic                        fire;
  logic                        res_vld;
  sfr_pkg::result_t            res;

  // a held byte is parsed once the result register can take its result
  assign fire        = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || fire;

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.valid && in_ch.ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_address <= sfr_pkg::RST_STATION_ADDRESS;
      cfg_r.info_zero_code  <= sfr_pkg::RST_INFO_ZERO_CODE;
      cfg_r.info_one_code   <= sfr_pkg::RST_INFO_ONE_CODE;
      cfg_r.set_code        <= sfr_pkg::RST_SET_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::CFG_STATION_ADDRESS: cfg_r.station_address <= cfg_data;
        sfr_pkg::CFG_INFO_ZERO_CODE:  cfg_r.info_zero_code  <= cfg_data;
        sfr_pkg::CFG_INFO_ONE_CODE:   cfg_r.info_one_code   <= cfg_data;
        sfr_pkg::CFG_SET_CODE:        cfg_r.set_code        <= cfg_data;
        default:                      cfg_r                 <= cfg_r;
      endcase
    end
  end

  sfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  sfr_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire && res_vld),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  // a held byte that is not parsed stays in the input register
  `SFR_ASSERT_NEXT(a_in_hold, in_vld_r && !fire, in_vld_r && $stable(in_byte_r), "held input byte lost")

endmodule

[tb/sv/stuffed_frame_receiver_top_test.sv]
// testbench for the stuffed frame receiver: frame stimulus, byte-level predictor, result checks
module stuffed_frame_receiver_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTES_PER_PHASE = 100;
  localparam int PRESSURE_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;

  // predicts results from transferred line bytes and checks the ones the block returns
  class frame_scoreboard;
    sfr_pkg::cfg_t regs;
    sfr_pkg::state_t parse_state;
    bit expected_seq;
    bit frame_number;
    bit held_valid;
    logic [sfr_pkg::BYTE_W-1:0] held_byte;
    logic [sfr_pkg::BYTE_W-1:0] running_xor;
    logic [sfr_pkg::CNT_W-1:0] byte_count;
    sfr_pkg::result_t pending[$];
    int mismatches;
    int results_seen;
    int event_tally[6];

    function new();
      regs = '{sfr_pkg::RST_STATION_ADDRESS, sfr_pkg::RST_INFO_ZERO_CODE,
               sfr_pkg::RST_INFO_ONE_CODE, sfr_pkg::RST_SET_CODE};
      parse_state = sfr_pkg::ST_HUNT;
      expected_seq = 1'b0;
      frame_number = 1'b0;
      held_valid = 1'b0;
      held_byte = '0;
      running_xor = '0;
      byte_count = '0;
    endfunction

    function void set_register(logic [sfr_pkg::IDX_W-1:0] idx,
                               logic [sfr_pkg::BYTE_W-1:0] value);
      case (idx)
        sfr_pkg::CFG_STATION_ADDRESS: regs.station_address = value;
        sfr_pkg::CFG_INFO_ZERO_CODE:  regs.info_zero_code = value;
        sfr_pkg::CFG_INFO_ONE_CODE:   regs.info_one_code = value;
        default:                      regs.set_code = value;
      endcase
    endfunction

    function void push_event(logic [sfr_pkg::KIND_W-1:0] kind,
                             logic [sfr_pkg::BYTE_W-1:0] pay,
                             logic [sfr_pkg::RPK_W-1:0] rkind, logic rnum,
                             logic [sfr_pkg::CNT_W-1:0] len);
      sfr_pkg::result_t r;
      r.event_kind = kind;
      r.payload_byte = pay;
      r.reply_valid = (kind != sfr_pkg::EV_PAYLOAD);
      r.reply_kind = rkind;
      r.reply_number = rnum;
      r.payload_length = len;
      r.expected_number = expected_seq;
      pending.push_back(r);
    endfunction

    function void reject_frame();
      parse_state = sfr_pkg::ST_HUNT;
      push_event(sfr_pkg::EV_REJECT, sfr_pkg::ZERO_BYTE, sfr_pkg::RP_REJ, frame_number, '0);
    endfunction

    // destuffed byte: release the held one, keep this one back
    function void take_payload(logic [sfr_pkg::BYTE_W-1:0] d);
      if (held_valid) begin
        if (byte_count >= sfr_pkg::MAX_PAYLOAD) begin
          reject_frame();
          return;
        end
        byte_count++;
        push_event(sfr_pkg::EV_PAYLOAD, held_byte, sfr_pkg::RP_RR, 1'b0, '0);
      end
      held_byte = d;
      held_valid = 1'b1;
      running_xor ^= d;
      parse_state = sfr_pkg::ST_DATA;
    endfunction

    function void note_line_byte(logic [sfr_pkg::BYTE_W-1:0] b);
      logic [sfr_pkg::BYTE_W-1:0] ctrl;
      case (parse_state)
        sfr_pkg::ST_FLAG: begin
          if (b == regs.station_address) parse_state = sfr_pkg::ST_ADDR;
          else if (b != sfr_pkg::FLAG_BYTE) parse_state = sfr_pkg::ST_HUNT;
        end
        sfr_pkg::ST_ADDR: begin
          if ((b == regs.info_zero_code && expected_seq) ||
              (b == regs.info_one_code && !expected_seq)) begin
            parse_state = sfr_pkg::ST_HUNT;
            push_event(sfr_pkg::EV_DUP, sfr_pkg::ZERO_BYTE, sfr_pkg::RP_RR, expected_seq, '0);
          end else if (b == regs.info_zero_code) begin
            frame_number = 1'b0;
            parse_state = sfr_pkg::ST_INFO_C;
          end else if (b == regs.info_one_code) begin
            frame_number = 1'b1;
            parse_state = sfr_pkg::ST_INFO_C;
          end else if (b == regs.set_code) begin
            parse_state = sfr_pkg::ST_SET_C;
          end else if (b == sfr_pkg::FLAG_BYTE) begin
            parse_state = sfr_pkg::ST_FLAG;
          end else begin
            parse_state = sfr_pkg::ST_HUNT;
          end
        end
        sfr_pkg::ST_INFO_C: begin
          ctrl = frame_number ? regs.info_one_code : regs.info_zero_code;
          if (b == (regs.station_address ^ ctrl)) begin
            parse_state = sfr_pkg::ST_DATA;
            held_byte = '0;
            held_valid = 1'b0;
            running_xor = '0;
            byte_count = '0;
          end else if (b == sfr_pkg::FLAG_BYTE) begin
            parse_state = sfr_pkg::ST_FLAG;
          end else begin
            parse_state = sfr_pkg::ST_HUNT;
            push_event(sfr_pkg::EV_HDR, sfr_pkg::ZERO_BYTE, sfr_pkg::RP_RR, expected_seq, '0);
          end
        end
        sfr_pkg::ST_SET_C: begin
          if (b == (regs.station_address ^ regs.set_code)) begin
            parse_state = sfr_pkg::ST_HUNT;
            push_event(sfr_pkg::EV_SET, sfr_pkg::ZERO_BYTE, sfr_pkg::RP_UA, 1'b0, '0);
          end else begin
            parse_state = (b == sfr_pkg::FLAG_BYTE) ? sfr_pkg::ST_FLAG : sfr_pkg::ST_HUNT;
          end
        end
        sfr_pkg::ST_DATA: begin
          if (b == sfr_pkg::ESC_BYTE) begin
            parse_state = sfr_pkg::ST_ESC;
          end else if (b == sfr_pkg::FLAG_BYTE) begin
            // closing flag: needs a payload and a zero check sum
            if (held_valid && byte_count >= 13'd1 && running_xor == sfr_pkg::ZERO_BYTE) begin
              parse_state = sfr_pkg::ST_HUNT;
              expected_seq = !frame_number;
              push_event(sfr_pkg::EV_ACCEPT, sfr_pkg::ZERO_BYTE, sfr_pkg::RP_RR, expected_seq,
                         byte_count);
            end else begin
              reject_frame();
            end
          end else begin
            take_payload(b);
          end
        end
        sfr_pkg::ST_ESC: begin
          if (b == sfr_pkg::ESC_FLAG) take_payload(sfr_pkg::FLAG_BYTE);
          else if (b == sfr_pkg::ESC_ESC) take_payload(sfr_pkg::ESC_BYTE);
          else reject_frame();
        end
        default: parse_state = (b == sfr_pkg::FLAG_BYTE) ? sfr_pkg::ST_FLAG : sfr_pkg::ST_HUNT;
      endcase
    endfunction

    function void check_result(sfr_pkg::result_t got);
      sfr_pkg::result_t want;
      bit bad;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind %0d byte %h with nothing pending",
                   got.event_kind, got.payload_byte);
        return;
      end
      want = pending.pop_front();
      event_tally[want.event_kind]++;
      bad = (got.event_kind !== want.event_kind) ||
            (got.payload_byte !== want.payload_byte) ||
            (got.reply_valid !== want.reply_valid) ||
            (got.reply_kind !== want.reply_kind) ||
            (got.reply_number !== want.reply_number) ||
            (got.payload_length !== want.payload_length) ||
            (got.expected_number !== want.expected_number);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result %0d mismatch: expected kind %0d byte %h reply %0b/%0d/%0d",
                    " len %0d seq %0d, got kind %0d byte %h reply %0b/%0d/%0d len %0d seq %0d"},
                   results_seen, want.event_kind, want.payload_byte, want.reply_valid,
                   want.reply_kind, want.reply_number, want.payload_length,
                   want.expected_number, got.event_kind, got.payload_byte, got.reply_valid,
                   got.reply_kind, got.reply_number, got.payload_length, got.expected_number);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sfr_pkg::IDX_W-1:0] cfg_index;
  logic [sfr_pkg::BYTE_W-1:0] cfg_data;

  sfr_in_if in_bus();
  sfr_out_if out_bus();

  stuffed_frame_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_scoreboard sb;
  logic [sfr_pkg::BYTE_W-1:0] line_q[$];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request = 0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int bytes_sent;
  int settings_written;
  int unsigned cycle_count;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stuffed_frame_receiver_top_test failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_request > 0 && !hold_taken) begin
      hold_left = hold_request;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check every result transfer
  always @(posedge clk) begin : collect_results
    sfr_pkg::result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.event_kind = out_bus.event_kind;
      got.payload_byte = out_bus.payload_byte;
      got.reply_valid = out_bus.reply_valid;
      got.reply_kind = out_bus.reply_kind;
      got.reply_number = out_bus.reply_number;
      got.payload_length = out_bus.payload_length;
      got.expected_number = out_bus.expected_number;
      sb.check_result(got);
    end
  end

  // line bytes queued in line_q go out one transfer at a time
  task automatic send_line();
    logic [sfr_pkg::BYTE_W-1:0] b;
    while (line_q.size() != 0) begin
      b = line_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
      in_bus.valid <= 1'b1;
      in_bus.rx_byte <= b;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
      sb.note_line_byte(b);
      bytes_sent++;
    end
  endtask

  // wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(logic [sfr_pkg::IDX_W-1:0] idx,
                              logic [sfr_pkg::BYTE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic write_settings(sfr_pkg::cfg_t c);
    put_register(sfr_pkg::CFG_STATION_ADDRESS, c.station_address);
    put_register(sfr_pkg::CFG_INFO_ZERO_CODE, c.info_zero_code);
    put_register(sfr_pkg::CFG_INFO_ONE_CODE, c.info_one_code);
    put_register(sfr_pkg::CFG_SET_CODE, c.set_code);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // frame building
  function automatic logic [sfr_pkg::BYTE_W-1:0] pick_payload_byte();
    case ($urandom_range(7))
      0: return sfr_pkg::FLAG_BYTE;
      1: return sfr_pkg::ESC_BYTE;
      default: return sfr_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_length();
    if ($urandom_range(19) == 0) return $urandom_range(13, 60);
    return $urandom_range(1, 12);
  endfunction

  task automatic push_stuffed(logic [sfr_pkg::BYTE_W-1:0] d);
    if (d == sfr_pkg::FLAG_BYTE) begin
      line_q.push_back(sfr_pkg::ESC_BYTE);
      line_q.push_back(sfr_pkg::ESC_FLAG);
    end else if (d == sfr_pkg::ESC_BYTE) begin
      line_q.push_back(sfr_pkg::ESC_BYTE);
      line_q.push_back(sfr_pkg::ESC_ESC);
    end else begin
      line_q.push_back(d);
    end
  endtask

  task automatic push_info_header(bit number, bit bad_bcc1);
    logic [sfr_pkg::BYTE_W-1:0] ctrl;
    logic [sfr_pkg::BYTE_W-1:0] bcc;
    ctrl = number ? sb.regs.info_one_code : sb.regs.info_zero_code;
    bcc = sb.regs.station_address ^ ctrl;
    if (bad_bcc1) bcc ^= sfr_pkg::BYTE_W'($urandom_range(1, 255));
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(sb.regs.station_address);
    line_q.push_back(ctrl);
    line_q.push_back(bcc);
  endtask

  task automatic add_info_frame(bit number, int len, bit bad_bcc1, bit bad_bcc2);
    logic [sfr_pkg::BYTE_W-1:0] d;
    logic [sfr_pkg::BYTE_W-1:0] sum;
    sum = '0;
    push_info_header(number, bad_bcc1);
    for (int i = 0; i < len; i++) begin
      d = pick_payload_byte();
      push_stuffed(d);
      sum ^= d;
    end
    if (bad_bcc2) sum ^= sfr_pkg::BYTE_W'($urandom_range(1, 255));
    push_stuffed(sum);
    line_q.push_back(sfr_pkg::FLAG_BYTE);
  endtask

  task automatic add_set_frame(bit bad_bcc1);
    logic [sfr_pkg::BYTE_W-1:0] bcc;
    bcc = sb.regs.station_address ^ sb.regs.set_code;
    if (bad_bcc1) bcc ^= sfr_pkg::BYTE_W'($urandom_range(1, 255));
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(sb.regs.station_address);
    line_q.push_back(sb.regs.set_code);
    line_q.push_back(bcc);
  endtask

  task automatic add_bad_escape_frame(bit number);
    logic [sfr_pkg::BYTE_W-1:0] d;
    int len;
    len = $urandom_range(0, 4);
    push_info_header(number, 1'b0);
    for (int i = 0; i < len; i++) push_stuffed(pick_payload_byte());
    d = sfr_pkg::BYTE_W'($urandom_range(255));
    if (d == sfr_pkg::ESC_FLAG || d == sfr_pkg::ESC_ESC) d = sfr_pkg::ZERO_BYTE;
    line_q.push_back(sfr_pkg::ESC_BYTE);
    line_q.push_back(d);
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) line_q.push_back(pick_payload_byte());
      else line_q.push_back(sfr_pkg::BYTE_W'($urandom_range(255)));
    end
  endtask

  // mostly well-formed frames, the rest flawed frames and line noise
  task automatic random_traffic(int budget);
    int first_byte;
    int pick;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < budget) begin
      pick = $urandom_range(99);
      if (pick < 55) add_info_frame(sb.expected_seq, pick_length(), 1'b0, 1'b0);
      else if (pick < 62) add_info_frame(!sb.expected_seq, pick_length(), 1'b0, 1'b0);
      else if (pick < 68) add_set_frame(1'b0);
      else if (pick < 72) add_set_frame(1'b1);
      else if (pick < 77) add_info_frame(sb.expected_seq, pick_length(), 1'b1, 1'b0);
      else if (pick < 83) add_info_frame(sb.expected_seq, pick_length(), 1'b0, 1'b1);
      else if (pick < 88) add_bad_escape_frame(sb.expected_seq);
      else if (pick < 92) add_info_frame(sb.expected_seq, 0, 1'b0, 1'b0);
      else add_noise($urandom_range(1, 6));
      send_line();
    end
  endtask

  // main sequence
  initial begin
    sfr_pkg::cfg_t defaults;
    sfr_pkg::cfg_t phase_regs[6];
    logic [sfr_pkg::BYTE_W-1:0] addr;
    sb = new();
    defaults = '{sfr_pkg::RST_STATION_ADDRESS, sfr_pkg::RST_INFO_ZERO_CODE,
                 sfr_pkg::RST_INFO_ONE_CODE, sfr_pkg::RST_SET_CODE};
    phase_regs[0] = '{8'h00, 8'hff, 8'h01, 8'h80};
    phase_regs[1] = '{8'hff, sfr_pkg::FLAG_BYTE, sfr_pkg::ESC_BYTE, sfr_pkg::ZERO_BYTE};
    phase_regs[2] = '{8'h5a, 8'h11, 8'h11, 8'h11};
    phase_regs[3] = '{sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255))};
    phase_regs[4] = defaults;
    phase_regs[5] = '{sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255)),
                      sfr_pkg::BYTE_W'($urandom_range(255))};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= sfr_pkg::CFG_STATION_ADDRESS;
    cfg_data <= sfr_pkg::ZERO_BYTE;
    in_bus.valid <= 1'b0;
    in_bus.rx_byte <= sfr_pkg::ZERO_BYTE;
    send_idle_pct = 7;
    recv_idle_pct = 73;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_settings(defaults);

    // directed frames under the reset settings
    addr = sb.regs.station_address;
    add_set_frame(1'b0);
    // frame 0 carrying both extremes and both stuffed codes
    push_info_header(1'b0, 1'b0);
    push_stuffed(8'hff);
    push_stuffed(sfr_pkg::ZERO_BYTE);
    push_stuffed(sfr_pkg::FLAG_BYTE);
    push_stuffed(sfr_pkg::ESC_BYTE);
    push_stuffed(8'hff ^ sfr_pkg::FLAG_BYTE ^ sfr_pkg::ESC_BYTE);
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    // frame 0 again is now a duplicate
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(addr);
    line_q.push_back(sb.regs.info_zero_code);
    // flag in place of bcc1 restarts the header, then a bad bcc1
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(addr);
    line_q.push_back(sb.regs.info_one_code);
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    push_info_header(1'b1, 1'b1);
    send_line();
    // bad escape, empty payload, set with flag as bcc1 then bad bcc1, bad bcc2
    add_bad_escape_frame(1'b1);
    push_info_header(1'b1, 1'b0);
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(sfr_pkg::FLAG_BYTE);
    line_q.push_back(addr);
    line_q.push_back(sb.regs.set_code);
    add_set_frame(1'b1);
    add_info_frame(1'b1, 2, 1'b0, 1'b1);
    send_line();
    settle();

    // random phases across settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      settle();
      send_idle_pct = (p < 2) ? 7 : (p < 4) ? 73 : 0;
      recv_idle_pct = (p < 2) ? 73 : (p < 4) ? 7 : 0;
      write_settings(phase_regs[p]);
      if (p == 4) hold_request = PRESSURE_CYCLES;
      random_traffic(BYTES_PER_PHASE);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d line bytes under %0d register settings, with stalls on both sides",
             bytes_sent, settings_written);
    $display("results: %0d payload, %0d accepted, %0d rejected, %0d dup, %0d hdr error, %0d set",
             sb.event_tally[sfr_pkg::EV_PAYLOAD], sb.event_tally[sfr_pkg::EV_ACCEPT],
             sb.event_tally[sfr_pkg::EV_REJECT], sb.event_tally[sfr_pkg::EV_DUP],
             sb.event_tally[sfr_pkg::EV_HDR], sb.event_tally[sfr_pkg::EV_SET]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("stuffed_frame_receiver_top_test passed");
    end else begin
      $display("stuffed_frame_receiver_top_test failed");
    end
    $finish;
  end

endmodule

[stuffed_frame_receiver_top.f]
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_parser.sv
rtl/sfr_result_reg.sv
rtl/stuffed_frame_receiver_top.sv
tb/sv/stuffed_frame_receiver_top_test.sv
